@@ rtl/trce_pkg.sv @@
package trce_pkg;

    localparam int WORD_W = 16;
    localparam int ADDR_W = 15;
    localparam int COMP_W = 6;
    localparam int JUMP_W = 3;

    localparam int BIT_C_INSN = 15;
    localparam int BIT_USE_M  = 12;
    localparam int COMP_LSB   = 6;
    localparam int BIT_DEST_A = 5;
    localparam int BIT_DEST_D = 4;
    localparam int BIT_DEST_M = 3;

    localparam logic [COMP_W-1:0] COMP_ZERO    = 6'h2A;
    localparam logic [COMP_W-1:0] COMP_ONE     = 6'h3F;
    localparam logic [COMP_W-1:0] COMP_NEG_ONE = 6'h3A;
    localparam logic [COMP_W-1:0] COMP_D       = 6'h0C;
    localparam logic [COMP_W-1:0] COMP_Y       = 6'h30;
    localparam logic [COMP_W-1:0] COMP_NOT_D   = 6'h0D;
    localparam logic [COMP_W-1:0] COMP_NOT_Y   = 6'h31;
    localparam logic [COMP_W-1:0] COMP_NEG_D   = 6'h0F;
    localparam logic [COMP_W-1:0] COMP_NEG_Y   = 6'h33;
    localparam logic [COMP_W-1:0] COMP_D_INC   = 6'h1F;
    localparam logic [COMP_W-1:0] COMP_Y_INC   = 6'h37;
    localparam logic [COMP_W-1:0] COMP_D_DEC   = 6'h0E;
    localparam logic [COMP_W-1:0] COMP_Y_DEC   = 6'h32;
    localparam logic [COMP_W-1:0] COMP_ADD     = 6'h02;
    localparam logic [COMP_W-1:0] COMP_D_SUB_Y = 6'h13;
    localparam logic [COMP_W-1:0] COMP_Y_SUB_D = 6'h07;
    localparam logic [COMP_W-1:0] COMP_AND     = 6'h00;
    localparam logic [COMP_W-1:0] COMP_OR      = 6'h15;

    localparam logic [JUMP_W-1:0] JMP_NONE = 3'd0;
    localparam logic [JUMP_W-1:0] JMP_GT   = 3'd1;
    localparam logic [JUMP_W-1:0] JMP_EQ   = 3'd2;
    localparam logic [JUMP_W-1:0] JMP_GE   = 3'd3;
    localparam logic [JUMP_W-1:0] JMP_LT   = 3'd4;
    localparam logic [JUMP_W-1:0] JMP_NE   = 3'd5;
    localparam logic [JUMP_W-1:0] JMP_LE   = 3'd6;
    localparam logic [JUMP_W-1:0] JMP_ALL  = 3'd7;

    typedef struct packed {
        logic              ok;
        logic [WORD_W-1:0] value;
    } alu_result_t;

    function automatic alu_result_t alu_f(
        input logic              use_m,
        input logic [COMP_W-1:0] comp,
        input logic [WORD_W-1:0] d,
        input logic [WORD_W-1:0] a,
        input logic [WORD_W-1:0] m
    );
        alu_result_t       r;
        logic [WORD_W-1:0] y;
        y       = use_m ? m : a;
        r.ok    = 1'b1;
        r.value = '0;
        case (comp)
            COMP_ZERO:
            begin
                r.ok    = !use_m;
                r.value = '0;
            end
            COMP_ONE:
            begin
                r.ok    = !use_m;
                r.value = WORD_W'(1);
            end
            COMP_NEG_ONE:
            begin
                r.ok    = !use_m;
                r.value = '1;
            end
            COMP_D:
            begin
                r.ok    = !use_m;
                r.value = d;
            end
            COMP_NOT_D:
            begin
                r.ok    = !use_m;
                r.value = ~d;
            end
            COMP_NEG_D:
            begin
                r.ok    = !use_m;
                r.value = WORD_W'(0) - d;
            end
            COMP_D_INC:
            begin
                r.ok    = !use_m;
                r.value = d + WORD_W'(1);
            end
            COMP_D_DEC:
            begin
                r.ok    = !use_m;
                r.value = d - WORD_W'(1);
            end
            COMP_Y:       r.value = y;
            COMP_NOT_Y:   r.value = ~y;
            COMP_NEG_Y:   r.value = WORD_W'(0) - y;
            COMP_Y_INC:   r.value = y + WORD_W'(1);
            COMP_Y_DEC:   r.value = y - WORD_W'(1);
            COMP_ADD:     r.value = d + y;
            COMP_D_SUB_Y: r.value = d - y;
            COMP_Y_SUB_D: r.value = y - d;
            COMP_AND:     r.value = d & y;
            COMP_OR:      r.value = d | y;
            default:      r.ok = 1'b0;
        endcase
        if (!r.ok)
        begin
            r.value = '0;
        end
        return r;
    endfunction

endpackage

@@ rtl/two_register_cpu_execute.sv @@
// Channel | Handshake             | Payload
// --------+-----------------------+------------------------------------------------
// input   | in_valid / in_stall   | instruction, mem_in
// output  | out_valid / out_stall | mem_write, mem_addr, mem_wdata, next_pc, illegal
//
// One item per clock while out_stall is low; an item passes the input register, then the result register.
// A, D and PC update in the execute stage, so each item sees the state left by the one before.
// rst_n clears A, D, PC and both valid flags.
// in_stall rises only when the input register holds an item and the result register is
// held by out_stall.
module two_register_cpu_execute
    import trce_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [WORD_W-1:0]        instruction,
    input  logic signed [WORD_W-1:0] mem_in,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     mem_write,
    output logic [ADDR_W-1:0]        mem_addr,
    output logic signed [WORD_W-1:0] mem_wdata,
    output logic [ADDR_W-1:0]        next_pc,
    output logic                     illegal
);

    logic              in_valid_reg;
    logic [WORD_W-1:0] ins_reg;
    logic [WORD_W-1:0] m_reg;

    logic [WORD_W-1:0] a_reg, a_next;
    logic [WORD_W-1:0] d_reg, d_next;
    logic [ADDR_W-1:0] pc_reg, pc_next;

    logic              out_valid_reg;
    logic              mem_write_reg, mem_write_next;
    logic [ADDR_W-1:0] mem_addr_reg;
    logic [WORD_W-1:0] wdata_reg, wdata_next;
    logic              illegal_reg, illegal_next;

    logic        out_free;
    logic        fire;
    logic        in_take;
    alu_result_t alu_res;
    logic        neg;
    logic        zero;
    logic        jump;

    assign out_free = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        alu_res = alu_f(ins_reg[BIT_USE_M], ins_reg[COMP_LSB +: COMP_W], d_reg, a_reg, m_reg);
        neg     = alu_res.value[WORD_W-1];
        zero    = (alu_res.value == '0);
        case (ins_reg[JUMP_W-1:0])
            JMP_GT:  jump = !neg && !zero;
            JMP_EQ:  jump = zero;
            JMP_GE:  jump = !neg;
            JMP_LT:  jump = neg;
            JMP_NE:  jump = !zero;
            JMP_LE:  jump = neg || zero;
            JMP_ALL: jump = 1'b1;
            default: jump = 1'b0;
        endcase

        a_next         = a_reg;
        d_next         = d_reg;
        pc_next        = pc_reg + ADDR_W'(1);
        mem_write_next = 1'b0;
        wdata_next     = '0;
        illegal_next   = 1'b0;
        if (!ins_reg[BIT_C_INSN])
        begin
            a_next = ins_reg;
        end
        else if (!alu_res.ok)
        begin
            illegal_next = 1'b1;
        end
        else
        begin
            mem_write_next = ins_reg[BIT_DEST_M];
            wdata_next     = ins_reg[BIT_DEST_M] ? alu_res.value : '0;
            if (ins_reg[BIT_DEST_D])
            begin
                d_next = alu_res.value;
            end
            if (ins_reg[BIT_DEST_A])
            begin
                a_next = alu_res.value;
            end
            if (jump)
            begin
                pc_next = a_reg[ADDR_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            a_reg         <= '0;
            d_reg         <= '0;
            pc_reg        <= '0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                a_reg  <= a_next;
                d_reg  <= d_next;
                pc_reg <= pc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ins_reg <= instruction;
            m_reg   <= WORD_W'(unsigned'(mem_in));
        end
        if (fire)
        begin
            mem_write_reg <= mem_write_next;
            mem_addr_reg  <= a_reg[ADDR_W-1:0];
            wdata_reg     <= wdata_next;
            illegal_reg   <= illegal_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign mem_write = mem_write_reg;
    assign mem_addr  = mem_addr_reg;
    assign mem_wdata = signed'(wdata_reg);
    assign next_pc   = pc_reg;
    assign illegal   = illegal_reg;

`ifndef NO_ASSERTIONS
    a_illegal_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(illegal && mem_write))
        else $error("illegal item wrote memory");

    a_wdata_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !mem_write) |-> (mem_wdata == '0))
        else $error("write data not zero without a write");

    a_load_a: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !ins_reg[BIT_C_INSN]) |=> (a_reg == $past(ins_reg)))
        else $error("A-instruction did not load A");

    a_illegal_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && illegal_next) |=> ($stable(a_reg) && $stable(d_reg)))
        else $error("illegal item changed A or D");

    a_pc_matches_output: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (next_pc == $past(pc_next)))
        else $error("next_pc differs from executed PC");
`endif

endmodule

@@ test/two_register_cpu_execute_tb.sv @@
`timescale 1ns / 1ps

module two_register_cpu_execute_tb;
    import trce_pkg::*;

    localparam logic [COMP_W-1:0] COMP_UNLISTED = 6'h01;
    localparam int RANDOM_ITEMS = 1900;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 4;

    typedef struct packed {
        logic              mem_write;
        logic [ADDR_W-1:0] mem_addr;
        logic [WORD_W-1:0] mem_wdata;
        logic [ADDR_W-1:0] next_pc;
        logic              illegal;
    } exec_result_t;

    typedef struct packed {
        logic [WORD_W-1:0] insn;
        logic [WORD_W-1:0] mem_word;
    } insn_item_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [WORD_W-1:0]        instruction = '0;
    logic signed [WORD_W-1:0] mem_in = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic                     mem_write;
    logic [ADDR_W-1:0]        mem_addr;
    logic signed [WORD_W-1:0] mem_wdata;
    logic [ADDR_W-1:0]        next_pc;
    logic                     illegal;

    insn_item_t   pending_items[$];
    exec_result_t expected_results[$];

    logic [WORD_W-1:0] model_a = '0;
    logic [WORD_W-1:0] model_d = '0;
    logic [ADDR_W-1:0] model_pc = '0;

    int burst_left = 1;
    int gap_left = 0;
    int cycle_count = 0;
    int mismatch_count = 0;
    int results_seen = 0;
    logic [15:0] stall_pattern = '0;
    int pattern_age = 0;

    insn_item_t   next_item;
    exec_result_t predicted;
    exec_result_t observed;

    two_register_cpu_execute dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .instruction (instruction),
        .mem_in      (mem_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .mem_write   (mem_write),
        .mem_addr    (mem_addr),
        .mem_wdata   (mem_wdata),
        .next_pc     (next_pc),
        .illegal     (illegal)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // 0..7 ignore the second operand, 8..17 use A or M
    function automatic logic [COMP_W-1:0] comp_code(input int idx);
        case (idx)
            0:       return COMP_ZERO;
            1:       return COMP_ONE;
            2:       return COMP_NEG_ONE;
            3:       return COMP_D;
            4:       return COMP_NOT_D;
            5:       return COMP_NEG_D;
            6:       return COMP_D_INC;
            7:       return COMP_D_DEC;
            8:       return COMP_Y;
            9:       return COMP_NOT_Y;
            10:      return COMP_NEG_Y;
            11:      return COMP_Y_INC;
            12:      return COMP_Y_DEC;
            13:      return COMP_ADD;
            14:      return COMP_D_SUB_Y;
            15:      return COMP_Y_SUB_D;
            16:      return COMP_AND;
            default: return COMP_OR;
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] c_insn(input logic use_m,
                                                 input logic [COMP_W-1:0] comp,
                                                 input logic [2:0] dest,
                                                 input logic [JUMP_W-1:0] jump);
        return {1'b1, 2'b11, use_m, comp, dest, jump};
    endfunction

    task automatic execute_insn(input logic [WORD_W-1:0] insn,
                                input logic [WORD_W-1:0] mem_word,
                                output exec_result_t res);
        logic [WORD_W-1:0] old_a;
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] val;
        logic [COMP_W-1:0] comp;
        logic              use_m;
        logic              legal;
        logic              y_free;
        logic              take;
        old_a  = model_a;
        use_m  = insn[BIT_USE_M];
        comp   = insn[COMP_LSB +: COMP_W];
        y      = use_m ? mem_word : model_a;
        val    = '0;
        legal  = 1'b1;
        y_free = 1'b0;
        take   = 1'b0;
        res    = '0;
        res.mem_addr = old_a[ADDR_W-1:0];
        res.next_pc  = model_pc + 1'b1;
        if (!insn[BIT_C_INSN])
        begin
            model_a = insn;
        end
        else
        begin
            case (comp)
                COMP_ZERO:    begin val = '0;                y_free = 1'b1; end
                COMP_ONE:     begin val = 16'd1;             y_free = 1'b1; end
                COMP_NEG_ONE: begin val = '1;                y_free = 1'b1; end
                COMP_D:       begin val = model_d;           y_free = 1'b1; end
                COMP_NOT_D:   begin val = ~model_d;          y_free = 1'b1; end
                COMP_NEG_D:   begin val = 16'd0 - model_d;   y_free = 1'b1; end
                COMP_D_INC:   begin val = model_d + 16'd1;   y_free = 1'b1; end
                COMP_D_DEC:   begin val = model_d - 16'd1;   y_free = 1'b1; end
                COMP_Y:       val = y;
                COMP_NOT_Y:   val = ~y;
                COMP_NEG_Y:   val = 16'd0 - y;
                COMP_Y_INC:   val = y + 16'd1;
                COMP_Y_DEC:   val = y - 16'd1;
                COMP_ADD:     val = model_d + y;
                COMP_D_SUB_Y: val = model_d - y;
                COMP_Y_SUB_D: val = y - model_d;
                COMP_AND:     val = model_d & y;
                COMP_OR:      val = model_d | y;
                default:      legal = 1'b0;
            endcase
            if (use_m && y_free)
            begin
                legal = 1'b0;
            end
            if (!legal)
            begin
                res.illegal = 1'b1;
            end
            else
            begin
                res.mem_write = insn[BIT_DEST_M];
                res.mem_wdata = insn[BIT_DEST_M] ? val : '0;
                if (insn[BIT_DEST_D])
                begin
                    model_d = val;
                end
                if (insn[BIT_DEST_A])
                begin
                    model_a = val;
                end
                case (insn[JUMP_W-1:0])
                    JMP_GT:  take = !val[WORD_W-1] && (val != 0);
                    JMP_EQ:  take = (val == 0);
                    JMP_GE:  take = !val[WORD_W-1];
                    JMP_LT:  take = val[WORD_W-1];
                    JMP_NE:  take = (val != 0);
                    JMP_LE:  take = val[WORD_W-1] || (val == 0);
                    JMP_ALL: take = 1'b1;
                    default: take = 1'b0;
                endcase
                if (take)
                begin
                    res.next_pc = old_a[ADDR_W-1:0];
                end
            end
        end
        model_pc = res.next_pc;
    endtask

    task automatic add_item(input logic [WORD_W-1:0] insn, input logic [WORD_W-1:0] mem_word);
        insn_item_t item;
        item.insn     = insn;
        item.mem_word = mem_word;
        pending_items.push_back(item);
    endtask

    function automatic logic [WORD_W-1:0] random_mem_word();
        logic [WORD_W-1:0] w;
        w = WORD_W'($urandom);
        if ($urandom_range(0, 7) == 0)
        begin
            case ($urandom_range(0, 4))
                0:       w = 16'h8000;
                1:       w = 16'h7FFF;
                2:       w = 16'h0000;
                3:       w = 16'hFFFF;
                default: w = 16'h0001;
            endcase
        end
        return w;
    endfunction

    function automatic logic [WORD_W-1:0] random_insn();
        logic [WORD_W-1:0] w;
        logic              use_m;
        int                kind;
        kind  = $urandom_range(0, 9);
        use_m = 1'($urandom);
        if (kind <= 2)
        begin
            w = {1'b0, ADDR_W'($urandom)};
        end
        else if (kind <= 8)
        begin
            w = c_insn(use_m, comp_code(use_m ? $urandom_range(8, 17) : $urandom_range(0, 17)),
                       3'($urandom), JUMP_W'($urandom));
            w[14:13] = 2'($urandom);
        end
        else
        begin
            w = WORD_W'($urandom);
        end
        return w;
    endfunction

    // sender: bursts of random length separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
            begin
                execute_insn(instruction, mem_in, predicted);
                expected_results.push_back(predicted);
            end
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                next_item = pending_items.pop_front();
                instruction <= next_item.insn;
                mem_in      <= next_item.mem_word;
                in_valid    <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                begin
                    burst_left = burst_left - 1;
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: rotating 16-bit stall pattern, replaced by a new random one when pattern_age wraps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (pattern_age == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       stall_pattern = '0;
                    1:       stall_pattern = 16'($urandom);
                    2:       stall_pattern = 16'($urandom) & 16'($urandom);
                    default: stall_pattern = 16'($urandom) | 16'($urandom);
                endcase
            end
            pattern_age = (pattern_age + 1) % 64;
            out_stall <= stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            observed.mem_write = mem_write;
            observed.mem_addr  = mem_addr;
            observed.mem_wdata = mem_wdata;
            observed.next_pc   = next_pc;
            observed.illegal   = illegal;
            if (expected_results.size() == 0)
            begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= 10)
                begin
                    $display("unexpected item %0d: w=%0b addr=%h data=%h pc=%h ill=%0b",
                             results_seen, mem_write, mem_addr, mem_wdata, next_pc, illegal);
                end
            end
            else
            begin
                predicted = expected_results.pop_front();
                if (observed.mem_write !== predicted.mem_write
                    || observed.mem_addr !== predicted.mem_addr
                    || observed.mem_wdata !== predicted.mem_wdata
                    || observed.next_pc !== predicted.next_pc
                    || observed.illegal !== predicted.illegal)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                    begin
                        $display("mismatch item %0d: exp w=%0b addr=%h data=%h pc=%h ill=%0b",
                                 results_seen, predicted.mem_write, predicted.mem_addr,
                                 predicted.mem_wdata, predicted.next_pc, predicted.illegal);
                        $display("                    got w=%0b addr=%h data=%h pc=%h ill=%0b",
                                 mem_write, mem_addr, mem_wdata, next_pc, illegal);
                    end
                end
            end
            results_seen = results_seen + 1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        add_item(16'h0000, 16'h0000);
        add_item(16'h7FFF, 16'h7FFF);
        for (int i = 0; i < 18; i++)
        begin
            add_item(c_insn(1'b0, comp_code(i), 3'(i), JUMP_W'(i + 3)),
                     i[0] ? 16'h8000 : 16'h7FFF);
        end
        // M operand with a constant-only code, then a code outside the table
        add_item(c_insn(1'b1, COMP_ZERO, 3'b111, JMP_ALL), 16'h8000);
        add_item(c_insn(1'b0, COMP_UNLISTED, 3'b111, JMP_ALL), 16'hFFFF);
        // A=M with a jump: target is A before the write
        add_item(16'h1234, 16'h5678);
        add_item(c_insn(1'b1, COMP_Y, 3'b100, JMP_ALL), 16'h7FFF);
        // PC wraps past the top address
        add_item(c_insn(1'b0, COMP_ZERO, 3'b000, JMP_ALL), 16'h0000);
        add_item(16'h0000, 16'hFFFF);
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            add_item(random_insn(), random_mem_word());
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || in_valid)
        begin
            @(negedge clk);
        end
        while (expected_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/trce_pkg.sv
rtl/two_register_cpu_execute.sv
test/two_register_cpu_execute_tb.sv
